[src/tpcg_pkg.sv]
package tpcg_pkg;

    localparam int NUM_ROWS    = 45;
    localparam int NUM_SECTORS = 24;
    localparam int INNER_ROWS  = 13;
    localparam int EAST_OFFSET = 12;
    localparam int ROM_ROWS    = 45;
    localparam int ROM_SECTORS = 24;

    // queue depth must be a power of two (pointers wrap)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_PITCH = 3'd0,
        REG_OUTER_PITCH = 3'd1,
        REG_INNER_DRIFT = 3'd2,
        REG_OUTER_DRIFT = 3'd3,
        REG_LEN_PER_TB  = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] INNER_PITCH_RST = 16'd21955;
    localparam logic [15:0] OUTER_PITCH_RST = 16'd43909;
    localparam logic [17:0] INNER_DRIFT_RST = 18'd205484;
    localparam logic [17:0] OUTER_DRIFT_RST = 18'd205965;
    localparam logic [15:0] LEN_PER_TB_RST  = 16'd37666;

    typedef logic signed [17:0] trig_t;

    typedef struct packed {
        logic [15:0] inner_pitch;
        logic [15:0] outer_pitch;
        logic [17:0] inner_drift;
        logic [17:0] outer_drift;
        logic [15:0] len_per_tb;
    } cfg_t;

    // classified hit, front to back
    typedef struct packed {
        logic        bad;
        logic        east;
        logic [13:0] pad;
        logic [14:0] tb;
        logic [6:0]  half_pads;
        logic [17:0] radius;
        trig_t       sin_s;
        trig_t       cos_s;
        trig_t       sin_e;
        trig_t       cos_e;
        logic [15:0] pitch;
        logic [17:0] drift;
    } item_t;

    localparam logic [6:0] HALF_PADS [ROM_ROWS] = '{
        7'd44, 7'd48, 7'd52, 7'd56, 7'd59, 7'd63, 7'd67, 7'd71, 7'd75, 7'd79,
        7'd83, 7'd87, 7'd91,
        7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd53, 7'd54, 7'd55, 7'd56, 7'd56,
        7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd61, 7'd62, 7'd63, 7'd64, 7'd64,
        7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd69, 7'd70, 7'd71, 7'd72, 7'd72,
        7'd72, 7'd72
    };

    // row radius, cm, 10 fractional bits
    localparam logic [17:0] RADIUS [ROM_ROWS] = '{
        18'd61440,  18'd66355,  18'd71270,  18'd76186,  18'd81101,  18'd86016,
        18'd90931,  18'd95846,  18'd101171, 18'd106496, 18'd111821, 18'd117146,
        18'd122470,
        18'd130248, 18'd132296, 18'd134344, 18'd136392, 18'd138440, 18'd140488,
        18'd142536, 18'd144584, 18'd146632, 18'd148680, 18'd150728, 18'd152776,
        18'd154824, 18'd156872, 18'd158920, 18'd160968, 18'd163016, 18'd165064,
        18'd167112, 18'd169160, 18'd171208, 18'd173256, 18'd175304, 18'd177352,
        18'd179400, 18'd181448, 18'd183496, 18'd185544, 18'd187592, 18'd189640,
        18'd191688, 18'd193736
    };

    // sin/cos in 16 fractional bits, 30 degree steps
    localparam trig_t Q_ONE  = 18'sd65536;
    localparam trig_t Q_R3H  = 18'sd56755;
    localparam trig_t Q_HALF = 18'sd32768;
    localparam trig_t Q_ZERO = 18'sd0;

    localparam trig_t SIN_ROM [ROM_SECTORS] = '{
        Q_HALF, Q_R3H, Q_ONE, Q_R3H, Q_HALF, Q_ZERO,
        -Q_HALF, -Q_R3H, -Q_ONE, -Q_R3H, -Q_HALF, Q_ZERO,
        -Q_HALF, -Q_R3H, -Q_ONE, -Q_R3H, -Q_HALF, Q_ZERO,
        Q_HALF, Q_R3H, Q_ONE, Q_R3H, Q_HALF, Q_ZERO
    };

    localparam trig_t COS_ROM [ROM_SECTORS] = '{
        Q_R3H, Q_HALF, Q_ZERO, -Q_HALF, -Q_R3H, -Q_ONE,
        -Q_R3H, -Q_HALF, Q_ZERO, Q_HALF, Q_R3H, Q_ONE,
        -Q_R3H, -Q_HALF, Q_ZERO, Q_HALF, Q_R3H, Q_ONE,
        Q_R3H, Q_HALF, Q_ZERO, -Q_HALF, -Q_R3H, -Q_ONE
    };

endpackage

[src/tpcg_front.sv]
module tpcg_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [13:0]          pad_position,
    input  logic [14:0]          time_bucket,
    input  logic [5:0]           pad_row,
    input  logic [4:0]           sector_number,
    input  tpcg_pkg::cfg_t       cfg,
    input  logic                 q_ready,
    output logic                 q_push,
    output tpcg_pkg::item_t      q_item
);

    logic       row_ok;
    logic       sec_ok;
    logic       ok;
    logic       east;
    logic       inner;
    logic [5:0] row_idx;
    logic [4:0] sec_idx;
    logic [4:0] east_idx;

    assign row_ok = (pad_row != 6'd0) && (pad_row <= 6'(tpcg_pkg::NUM_ROWS))
                 && (pad_row <= 6'(tpcg_pkg::ROM_ROWS));
    assign sec_ok = (sector_number != 5'd0)
                 && (sector_number <= 5'(tpcg_pkg::NUM_SECTORS))
                 && (sector_number <= 5'(tpcg_pkg::ROM_SECTORS));
    assign ok     = row_ok && sec_ok;

    assign inner = pad_row <= 6'(tpcg_pkg::INNER_ROWS);
    assign east  = sector_number > 5'(tpcg_pkg::EAST_OFFSET);

    // keep ROM indexes in range for bad hits; their results are forced to zero
    assign row_idx  = ok ? (pad_row - 6'd1) : 6'd0;
    assign sec_idx  = ok ? (sector_number - 5'd1) : 5'd0;
    assign east_idx = (ok && east) ? (sector_number - 5'(tpcg_pkg::EAST_OFFSET + 1))
                                   : sec_idx;

    always_comb begin
        q_item.bad       = !ok;
        q_item.east      = east;
        q_item.pad       = pad_position;
        q_item.tb        = time_bucket;
        q_item.half_pads = tpcg_pkg::HALF_PADS[row_idx];
        q_item.radius    = tpcg_pkg::RADIUS[row_idx];
        q_item.sin_s     = tpcg_pkg::SIN_ROM[sec_idx];
        q_item.cos_s     = tpcg_pkg::COS_ROM[sec_idx];
        q_item.sin_e     = tpcg_pkg::SIN_ROM[east_idx];
        q_item.cos_e     = tpcg_pkg::COS_ROM[east_idx];
        q_item.pitch     = inner ? cfg.inner_pitch : cfg.outer_pitch;
        q_item.drift     = inner ? cfg.inner_drift : cfg.outer_drift;
    end

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

endmodule

[src/tpcg_queue.sv]
module tpcg_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tpcg_pkg::item_t  push_item,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output tpcg_pkg::item_t  pop_item
);

    tpcg_pkg::item_t                 mem [tpcg_pkg::QUEUE_DEPTH];
    logic [tpcg_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tpcg_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tpcg_pkg::QPTR_W:0]       count_reg;
    logic [tpcg_pkg::QPTR_W:0]       count_next;

    assign ready    = count_reg != (tpcg_pkg::QPTR_W+1)'(tpcg_pkg::QUEUE_DEPTH);
    assign valid    = count_reg != '0;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_item;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (tpcg_pkg::QPTR_W+1)'(tpcg_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push not counted");
`endif

endmodule

[src/tpcg_back.sv]
module tpcg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  tpcg_pkg::item_t    q_item,
    output logic               q_pop,
    input  logic [15:0]        len_per_tb,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_global_x,
    output logic signed [18:0] m_global_y,
    output logic signed [18:0] m_global_z,
    output logic               m_bad_index
);

    localparam logic signed [48:0] RND_28 = 49'sd134217728;
    localparam logic signed [32:0] RND_12 = 33'sd2048;

    function automatic logic [18:0] sat19(input logic signed [21:0] v);
        logic [18:0] r;
        if (v > 22'sd262143) begin
            r = 19'h3FFFF;
        end else if (v < -22'sd262144) begin
            r = 19'h40000;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

    logic en;

    // stage 1: local x and z
    logic                 s1_valid_reg;
    logic                 s1_bad_reg;
    logic                 s1_east_reg;
    logic signed [30:0]   s1_lx_reg;
    logic signed [31:0]   s1_lz_reg;
    logic [17:0]          s1_radius_reg;
    tpcg_pkg::trig_t      s1_sin_s_reg, s1_cos_s_reg, s1_sin_e_reg, s1_cos_e_reg;

    // stage 2: rotation products, rounded z
    logic                 s2_valid_reg;
    logic                 s2_bad_reg;
    logic signed [47:0]   s2_cx_reg;
    logic signed [35:0]   s2_sx_reg;
    logic signed [47:0]   s2_sy_reg;
    logic signed [35:0]   s2_cy_reg;
    logic signed [21:0]   s2_gz_reg;

    // stage 3: rounded x and y
    logic                 s3_valid_reg;
    logic                 s3_bad_reg;
    logic signed [20:0]   s3_gx_reg;
    logic signed [20:0]   s3_gy_reg;
    logic signed [21:0]   s3_gz_reg;

    logic                 m_valid_reg;
    logic                 m_bad_reg;
    logic [18:0]          m_gx_reg, m_gy_reg, m_gz_reg;

    logic signed [15:0]   p_full;
    logic signed [14:0]   p_off;
    logic signed [31:0]   lx_full;
    logic [30:0]          tb_len;
    logic signed [31:0]   lz;
    logic signed [32:0]   lz_rnd;
    logic signed [20:0]   gz_abs;
    logic signed [18:0]   radius_s1;
    logic signed [47:0]   cx, sy;
    logic signed [35:0]   sx, cy;
    logic signed [48:0]   gx_sum, gy_sum;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    // pad offset from row center, 6 fractional bits
    assign p_full  = signed'({2'b00, q_item.pad}) - signed'({3'b000, q_item.half_pads, 6'd0})
                   - 16'sd32;
    assign p_off   = p_full[14:0];
    assign lx_full = 32'(signed'({1'b0, q_item.pitch})) * 32'(p_off);
    assign tb_len  = 31'(q_item.tb) * 31'(len_per_tb);
    assign lz      = signed'({2'b00, q_item.drift, 12'd0}) - signed'({1'b0, tb_len});

    assign radius_s1 = signed'({1'b0, s1_radius_reg});
    assign cx        = 48'(s1_cos_s_reg) * 48'(s1_lx_reg);
    assign sy        = 48'(s1_sin_e_reg) * 48'(s1_lx_reg);
    assign sx        = 36'(s1_sin_s_reg) * 36'(radius_s1);
    assign cy        = 36'(s1_cos_e_reg) * 36'(radius_s1);
    assign lz_rnd    = 33'(s1_lz_reg) + RND_12;
    assign gz_abs    = lz_rnd[32:12];

    // products at 38 fractional bits; radius terms carry 12 fewer
    assign gx_sum = 49'(s2_cx_reg) + (49'(s2_sx_reg) <<< 12) + RND_28;
    assign gy_sum = (49'(s2_cy_reg) <<< 12) - 49'(s2_sy_reg) + RND_28;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_bad_reg    <= q_item.bad;
            s1_east_reg   <= q_item.east;
            s1_lx_reg     <= lx_full[30:0];
            s1_lz_reg     <= lz;
            s1_radius_reg <= q_item.radius;
            s1_sin_s_reg  <= q_item.sin_s;
            s1_cos_s_reg  <= q_item.cos_s;
            s1_sin_e_reg  <= q_item.sin_e;
            s1_cos_e_reg  <= q_item.cos_e;

            s2_bad_reg <= s1_bad_reg;
            s2_cx_reg  <= cx;
            s2_sx_reg  <= sx;
            s2_sy_reg  <= sy;
            s2_cy_reg  <= cy;
            s2_gz_reg  <= s1_east_reg ? -22'(gz_abs) : 22'(gz_abs);

            s3_bad_reg <= s2_bad_reg;
            s3_gx_reg  <= gx_sum[48:28];
            s3_gy_reg  <= gy_sum[48:28];
            s3_gz_reg  <= s2_gz_reg;

            m_bad_reg <= s3_bad_reg;
            m_gx_reg  <= s3_bad_reg ? 19'd0 : sat19(22'(s3_gx_reg));
            m_gy_reg  <= s3_bad_reg ? 19'd0 : sat19(22'(s3_gy_reg));
            m_gz_reg  <= s3_bad_reg ? 19'd0 : sat19(s3_gz_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bad_index = m_bad_reg;
    assign m_global_x  = m_gx_reg;
    assign m_global_y  = m_gy_reg;
    assign m_global_z  = m_gz_reg;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> (m_gx_reg == 19'd0 && m_gy_reg == 19'd0
                                        && m_gz_reg == 19'd0))
        else $error("bad hit with nonzero coordinates");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(s3_valid_reg) && $stable(s1_valid_reg)
                                      && !$past(q_pop)))
        else $error("pipeline moved while output stalled");

    a_out_from_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s3_valid_reg))
        else $error("result without item in last stage");
`endif

endmodule

[src/tpc_hit_raw_to_global_transform.sv]
// Hit transform: raw pad/time coordinates of a detector hit to global x, y, z.
//
// Input channel (s_valid/s_ready): one hit per item, pad position and time
// bucket with 6 fractional bits, pad row 1..45, sector 1..24.
// Result channel (m_valid/m_ready): one item per hit, global x, y, z in cm
// with 10 fractional bits, saturated to 19 bits signed; m_bad_index is set
// and all coordinates are zero when the row or the sector is out of range.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (pad pitches,
// drift lengths, length per time bucket); write only while the block is idle.
//
// Throughput is one hit per cycle while m_ready does not hold the output. A
// result becomes valid once its hit has left the classification queue and
// passed the offset/drift multiply stage, the rotation multiply, the round
// stage and the saturating output register. While a result waits on m_ready
// the arithmetic stages hold and the 4-entry queue keeps taking hits; s_ready
// drops only once it is full.
// Reset (aresetn low, synchronous) empties the queue and pipeline and loads
// the default calibration values.
module tpc_hit_raw_to_global_transform (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [13:0]                         s_pad_position,
    input  logic [14:0]                         s_time_bucket,
    input  logic [5:0]                          s_pad_row,
    input  logic [4:0]                          s_sector_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [18:0]                  m_global_x,
    output logic signed [18:0]                  m_global_y,
    output logic signed [18:0]                  m_global_z,
    output logic                                m_bad_index,
    input  logic                                cfg_we,
    input  logic [tpcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpcg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tpcg_pkg::cfg_t  cfg_reg;
    tpcg_pkg::item_t push_item;
    tpcg_pkg::item_t pop_item;
    logic            q_ready;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inner_pitch <= tpcg_pkg::INNER_PITCH_RST;
            cfg_reg.outer_pitch <= tpcg_pkg::OUTER_PITCH_RST;
            cfg_reg.inner_drift <= tpcg_pkg::INNER_DRIFT_RST;
            cfg_reg.outer_drift <= tpcg_pkg::OUTER_DRIFT_RST;
            cfg_reg.len_per_tb  <= tpcg_pkg::LEN_PER_TB_RST;
        end else if (cfg_we) begin
            case (tpcg_pkg::cfg_reg_t'(cfg_index))
                tpcg_pkg::REG_INNER_PITCH: cfg_reg.inner_pitch <= cfg_wdata[15:0];
                tpcg_pkg::REG_OUTER_PITCH: cfg_reg.outer_pitch <= cfg_wdata[15:0];
                tpcg_pkg::REG_INNER_DRIFT: cfg_reg.inner_drift <= cfg_wdata;
                tpcg_pkg::REG_OUTER_DRIFT: cfg_reg.outer_drift <= cfg_wdata;
                tpcg_pkg::REG_LEN_PER_TB:  cfg_reg.len_per_tb  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tpcg_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .pad_position  (s_pad_position),
        .time_bucket   (s_time_bucket),
        .pad_row       (s_pad_row),
        .sector_number (s_sector_number),
        .cfg           (cfg_reg),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    tpcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    tpcg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .len_per_tb  (cfg_reg.len_per_tb),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_global_x  (m_global_x),
        .m_global_y  (m_global_y),
        .m_global_z  (m_global_z),
        .m_bad_index (m_bad_index)
    );

endmodule

[test/tpc_hit_transform_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// calibration registers and predicts every hit's global position.
module tpc_hit_transform_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [13:0]                         s_pad_position,
    input  logic [14:0]                         s_time_bucket,
    input  logic [5:0]                          s_pad_row,
    input  logic [4:0]                          s_sector_number,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [18:0]                  m_global_x,
    input  logic signed [18:0]                  m_global_y,
    input  logic signed [18:0]                  m_global_z,
    input  logic                                m_bad_index,
    input  logic                                cfg_we,
    input  logic [tpcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpcg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int ROWS        = 45;
    localparam int SECTORS     = 24;
    localparam int INNER_LAST  = 13;
    localparam int EAST_FIRST  = 12;

    localparam longint SAT_HI = 262143;
    localparam longint SAT_LO = -262144;

    localparam int ONE = 65536;
    localparam int R3H = 56755;
    localparam int HLF = 32768;

    localparam int HALF_PADS_TBL [0:44] = '{
        44, 48, 52, 56, 59, 63, 67, 71, 75, 79, 83, 87, 91,
        49, 50, 51, 52, 53, 53, 54, 55, 56, 56, 57, 58,
        59, 60, 61, 61, 62, 63, 64, 64, 65, 66, 67, 68,
        69, 69, 70, 71, 72, 72, 72, 72
    };

    // row radius, 10 fractional bits
    localparam int RADIUS_TBL [0:44] = '{
        61440, 66355, 71270, 76186, 81101, 86016, 90931, 95846,
        101171, 106496, 111821, 117146, 122470,
        130248, 132296, 134344, 136392, 138440, 140488, 142536, 144584,
        146632, 148680, 150728, 152776, 154824, 156872, 158920, 160968,
        163016, 165064, 167112, 169160, 171208, 173256, 175304, 177352,
        179400, 181448, 183496, 185544, 187592, 189640, 191688, 193736
    };

    localparam int SIN_TBL [0:23] = '{
        HLF, R3H, ONE, R3H, HLF, 0, -HLF, -R3H, -ONE, -R3H, -HLF, 0,
        -HLF, -R3H, -ONE, -R3H, -HLF, 0, HLF, R3H, ONE, R3H, HLF, 0
    };

    localparam int COS_TBL [0:23] = '{
        R3H, HLF, 0, -HLF, -R3H, -ONE, -R3H, -HLF, 0, HLF, R3H, ONE,
        -R3H, -HLF, 0, HLF, R3H, ONE, R3H, HLF, 0, -HLF, -R3H, -ONE
    };

    typedef struct packed {
        logic [15:0] pitch_in;
        logic [15:0] pitch_out;
        logic [17:0] drift_in;
        logic [17:0] drift_out;
        logic [15:0] len_tb;
    } calib_t;

    localparam calib_t CAL_DEFAULT = '{
        pitch_in:  16'd21955,
        pitch_out: 16'd43909,
        drift_in:  18'd205484,
        drift_out: 18'd205965,
        len_tb:    16'd37666
    };

    typedef struct packed {
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        logic signed [18:0] gz;
        logic               bad;
    } hit_xyz_t;

    // add one half, then floor
    function automatic longint round_down_to(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [18:0] clamp19(input longint v);
        longint c;
        c = v;
        if (c > SAT_HI)
            c = SAT_HI;
        else if (c < SAT_LO)
            c = SAT_LO;
        return c[18:0];
    endfunction

    function automatic hit_xyz_t place_hit(input calib_t c, input logic [13:0] pad,
                                           input logic [14:0] tb, input logic [5:0] row,
                                           input logic [4:0] sec);
        hit_xyz_t r;
        int       ri;
        int       si;
        int       ei;
        logic     inner;
        longint   pitch;
        longint   drift;
        longint   lx;
        longint   ly;
        longint   lz;
        longint   gx;
        longint   gy;
        longint   gz;
        r = '0;
        if (row < 1 || row > ROWS || sec < 1 || sec > SECTORS) begin
            r.bad = 1'b1;
            return r;
        end
        ri = int'(row) - 1;
        si = int'(sec) - 1;
        ei = (sec > EAST_FIRST) ? int'(sec) - EAST_FIRST - 1 : si;
        inner = (row <= INNER_LAST);
        pitch = inner ? longint'(c.pitch_in) : longint'(c.pitch_out);
        drift = inner ? longint'(c.drift_in) : longint'(c.drift_out);
        // all local terms carry 22 fractional bits
        lx = pitch * (longint'(pad) - 64 * longint'(HALF_PADS_TBL[ri]) - 32);
        ly = longint'(RADIUS_TBL[ri]) * 4096;
        lz = drift * 4096 - longint'(tb) * longint'(c.len_tb);
        gx = longint'(COS_TBL[si]) * lx + longint'(SIN_TBL[si]) * ly;
        gy = -longint'(SIN_TBL[ei]) * lx + longint'(COS_TBL[ei]) * ly;
        gx = round_down_to(gx, 28);
        gy = round_down_to(gy, 28);
        gz = round_down_to(lz, 12);
        if (sec > EAST_FIRST)
            gz = -gz;
        r.gx = clamp19(gx);
        r.gy = clamp19(gy);
        r.gz = clamp19(gz);
        return r;
    endfunction

    hit_xyz_t expected_hits [$];
    calib_t   cal = CAL_DEFAULT;
    int       errs = 0;

    always @(posedge aclk) begin
        hit_xyz_t want;
        hit_xyz_t got;
        if (!aresetn) begin
            cal = CAL_DEFAULT;
            expected_hits.delete();
        end else begin
            if (s_valid && s_ready)
                expected_hits.push_back(place_hit(cal, s_pad_position, s_time_bucket,
                                                  s_pad_row, s_sector_number));
            if (m_valid && m_ready) begin
                got.gx  = m_global_x;
                got.gy  = m_global_y;
                got.gz  = m_global_z;
                got.bad = m_bad_index;
                if (expected_hits.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected item x=%0d y=%0d z=%0d bad=%b",
                             $time, got.gx, got.gy, got.gz, got.bad);
                end else begin
                    want = expected_hits.pop_front();
                    if (got !== want) begin
                        errs++;
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d bad=%b",
                                 $time, want.gx, want.gy, want.gz, want.bad);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d bad=%b",
                                 $time, got.gx, got.gy, got.gz, got.bad);
                    end
                end
            end
            // registers are only written while idle, so order against items is moot
            if (cfg_we) begin
                case (cfg_index)
                    tpcg_pkg::REG_INNER_PITCH: cal.pitch_in  = cfg_wdata[15:0];
                    tpcg_pkg::REG_OUTER_PITCH: cal.pitch_out = cfg_wdata[15:0];
                    tpcg_pkg::REG_INNER_DRIFT: cal.drift_in  = cfg_wdata[17:0];
                    tpcg_pkg::REG_OUTER_DRIFT: cal.drift_out = cfg_wdata[17:0];
                    tpcg_pkg::REG_LEN_PER_TB:  cal.len_tb    = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_hits.size();
        mismatches  <= errs;
    end

endmodule

[test/tpc_hit_raw_to_global_transform_test.sv]
`timescale 1ns / 100ps

module tpc_hit_raw_to_global_transform_test;

    localparam int HOLD_CYCLES = 80;
    // index past the register list, writes there must be dropped
    localparam logic [tpcg_pkg::CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [13:0]                        s_pad_position;
    logic [14:0]                        s_time_bucket;
    logic [5:0]                         s_pad_row;
    logic [4:0]                         s_sector_number;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [18:0]                 m_global_x;
    logic signed [18:0]                 m_global_y;
    logic signed [18:0]                 m_global_z;
    logic                               m_bad_index;
    logic                               cfg_we;
    logic [tpcg_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [tpcg_pkg::CFG_DATA_W-1:0]    cfg_wdata;

    int   mismatches;
    int   outstanding;
    logic idle_on;
    int   hold_requests;
    int   hits_sent;
    int   bad_hits_sent;
    int   settings_used;

    tpc_hit_raw_to_global_transform DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pad_position  (s_pad_position),
        .s_time_bucket   (s_time_bucket),
        .s_pad_row       (s_pad_row),
        .s_sector_number (s_sector_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_global_x      (m_global_x),
        .m_global_y      (m_global_y),
        .m_global_z      (m_global_z),
        .m_bad_index     (m_bad_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    tpc_hit_transform_checker u_hit_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pad_position  (s_pad_position),
        .s_time_bucket   (s_time_bucket),
        .s_pad_row       (s_pad_row),
        .s_sector_number (s_sector_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_global_x      (m_global_x),
        .m_global_y      (m_global_y),
        .m_global_z      (m_global_z),
        .m_bad_index     (m_bad_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls plus one long hold per request
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !(idle_on && $urandom_range(99) < 11);
        end
    end

    // valid stays high across back-to-back items unless idle_on inserts a random gap; callers drop it via wait_drained
    task automatic send_hit(input logic [13:0] pad, input logic [14:0] tb,
                            input logic [5:0] row, input logic [4:0] sec);
        if (idle_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_pad_position  <= pad;
        s_time_bucket   <= tb;
        s_pad_row       <= row;
        s_sector_number <= sec;
        do @(posedge aclk); while (!s_ready);
        hits_sent++;
        if (row == 0 || row > tpcg_pkg::NUM_ROWS || sec == 0 || sec > tpcg_pkg::NUM_SECTORS)
            bad_hits_sent++;
    endtask

    task automatic send_random_hits(input int count);
        logic [13:0] pad;
        logic [14:0] tb;
        logic [5:0]  row;
        logic [4:0]  sec;
        repeat (count) begin
            if ($urandom_range(99) < 90)
                row = 6'($urandom_range(tpcg_pkg::NUM_ROWS, 1));
            else
                row = $urandom_range(1) ? 6'd0
                                        : 6'($urandom_range(63, tpcg_pkg::NUM_ROWS + 1));
            if ($urandom_range(99) < 92)
                sec = 5'($urandom_range(tpcg_pkg::NUM_SECTORS, 1));
            else
                sec = $urandom_range(1) ? 5'd0
                                        : 5'($urandom_range(31, tpcg_pkg::NUM_SECTORS + 1));
            case ($urandom_range(7))
                0:       pad = '0;
                1:       pad = '1;
                2, 3:    pad = 14'($urandom_range(12287));
                default: pad = 14'($urandom);
            endcase
            case ($urandom_range(7))
                0:       tb = '0;
                1:       tb = '1;
                default: tb = 15'($urandom);
            endcase
            send_hit(pad, tb, row, sec);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // upper data bits are noise on the 16-bit registers
    task automatic load_calibration(input logic [15:0] pitch_in, input logic [15:0] pitch_out,
                                    input logic [17:0] drift_in, input logic [17:0] drift_out,
                                    input logic [15:0] len_tb);
        cfg_we    <= 1'b1;
        cfg_index <= tpcg_pkg::REG_INNER_PITCH;
        cfg_wdata <= {2'($urandom), pitch_in};
        @(posedge aclk);
        cfg_index <= tpcg_pkg::REG_OUTER_PITCH;
        cfg_wdata <= {2'($urandom), pitch_out};
        @(posedge aclk);
        cfg_index <= tpcg_pkg::REG_INNER_DRIFT;
        cfg_wdata <= drift_in;
        @(posedge aclk);
        cfg_index <= tpcg_pkg::REG_OUTER_DRIFT;
        cfg_wdata <= drift_out;
        @(posedge aclk);
        cfg_index <= tpcg_pkg::REG_LEN_PER_TB;
        cfg_wdata <= {2'($urandom), len_tb};
        @(posedge aclk);
        cfg_index <= REG_UNUSED_IDX;
        cfg_wdata <= '1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_pad_position  = '0;
        s_time_bucket   = '0;
        s_pad_row       = '0;
        s_sector_number = '0;
        cfg_we          = 1'b0;
        cfg_index       = tpcg_pkg::REG_INNER_PITCH;
        cfg_wdata       = '0;
        idle_on         = 1'b1;
        hold_requests   = 0;
        hits_sent       = 0;
        bad_hits_sent   = 0;
        settings_used   = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset calibration: corners, pad offset zero, inner/outer and east/west edges
        send_hit(14'd0, 15'd0, 6'd1, 5'd1);
        send_hit(14'h3FFF, 15'h7FFF, 6'd45, 5'd24);
        send_hit(14'd2848, 15'd0, 6'd1, 5'd12);
        send_hit(14'd5856, 15'd64, 6'd13, 5'd13);
        send_hit(14'd3168, 15'd64, 6'd14, 5'd7);
        send_hit(14'd8000, 15'd16384, 6'd30, 5'd18);
        send_hit(14'd12287, 15'd0, 6'd45, 5'd3);
        send_hit(14'd0, 15'h7FFF, 6'd14, 5'd9);
        send_hit(14'd4640, 15'd1000, 6'd44, 5'd13);
        send_hit(14'h2AAA, 15'h5555, 6'h15, 5'h0A);
        send_hit(14'h1555, 15'h2AAA, 6'h2A, 5'h15);
        // bad row or sector
        send_hit(14'd100, 15'd100, 6'd0, 5'd5);
        send_hit(14'd100, 15'd100, 6'd46, 5'd5);
        send_hit(14'd100, 15'd100, 6'd63, 5'd5);
        send_hit(14'd100, 15'd100, 6'd5, 5'd0);
        send_hit(14'd100, 15'd100, 6'd5, 5'd25);
        send_hit(14'd100, 15'd100, 6'd5, 5'd31);
        send_hit(14'h3FFF, 15'h7FFF, 6'd0, 5'd0);
        send_random_hits(250);
        wait_drained();

        // largest pitch and drift: outputs saturate
        load_calibration('1, '1, '1, '1, '1);
        send_random_hits(200);
        wait_drained();

        load_calibration('0, '0, '0, '0, '0);
        send_random_hits(150);
        wait_drained();

        // output held off while input keeps coming, then a gap-free stretch
        load_calibration(16'($urandom), 16'($urandom), 18'($urandom), 18'($urandom),
                         16'($urandom));
        hold_requests <= hold_requests + 1;
        send_random_hits(40);
        idle_on <= 1'b0;
        send_random_hits(150);
        idle_on <= 1'b1;
        wait_drained();
        send_random_hits(110);
        wait_drained();

        load_calibration(16'($urandom), 16'($urandom), 18'($urandom), 18'($urandom),
                         16'($urandom));
        send_random_hits(250);
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d hits (%0d with bad row or sector) over %0d calibrations,",
                 hits_sent, bad_hits_sent, settings_used);
        $display("with random stalls on both sides, one long output hold and a stall-free run.");
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
